// ===== rtl/julia_escape_time_top_macros.svh =====
// Assertion macros shared by the escape-time RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including module.
`ifndef JULIA_ESCAPE_TIME_TOP_MACROS_SVH
`define JULIA_ESCAPE_TIME_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JET_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jet_pkg.sv =====
// Shared types, register codes, reset values and the saturation helper.
// Used by every module of the Julia escape-time block; depends on nothing.
package jet_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_RADIUS     = 3'd0;
	localparam logic [2:0] REG_C_RE       = 3'd1;
	localparam logic [2:0] REG_C_IM       = 3'd2;
	localparam logic [2:0] REG_ITER_LIMIT = 3'd3;
	localparam logic [2:0] REG_STEP_RE    = 3'd4;
	localparam logic [2:0] REG_STEP_IM    = 3'd5;

	// Reset values of the registers.
	localparam logic [28:0]        RADIUS_RST     = 29'd134217728;
	localparam logic signed [31:0] C_RE_RST       = -32'sd46976204;
	localparam logic signed [31:0] C_IM_RST       = 32'sd18129543;
	localparam logic [15:0]        ITER_LIMIT_RST = 16'd1000;
	localparam logic [28:0]        STEP_RST       = 29'd268435;

	// Start-point queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [28:0]        radius;
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
		logic [15:0]        iter_limit;
		logic [28:0]        step_re;
		logic [28:0]        step_im;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] zr;
		logic signed [31:0] zi;
	} point_t;

	// Clamp a 41-bit signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -41'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return $signed(v[31:0]);
		end
	endfunction

endpackage

// ===== rtl/jet_front.sv =====
// Front part: accepts pixel requests, clamps them and forms the start point.
// Two stages: product pixel*step, then subtract radius with saturation. Uses jet_pkg.
module jet_front #(
	parameter int MAX_DIM = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  jet_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [9:0]      pix_x,
	input  logic [9:0]      pix_y,
	output logic            push_valid,
	input  logic            push_ready,
	output jet_pkg::point_t push_data
);
	import jet_pkg::*;

	localparam int MaxPix = MAX_DIM - 1;

	logic        s1_valid_q, s2_valid_q;
	logic [38:0] prod_x_s1, prod_y_s1;
	point_t      start_s2;
	logic [9:0]  px_clamp, py_clamp;
	logic        s1_load, s2_load, push;

	// Pixel indexes beyond the image are clamped to the last row or column.
	assign px_clamp = ({3'd0, pix_x} > 13'(MaxPix)) ? 10'(MaxPix) : pix_x;
	assign py_clamp = ({3'd0, pix_y} > 13'(MaxPix)) ? 10'(MaxPix) : pix_y;

	// Stage advance: each stage loads when it is empty or draining.
	assign push     = s2_valid_q && push_ready;
	assign s2_load  = s1_valid_q && (!s2_valid_q || push);
	assign in_stall = s1_valid_q && !s2_load;
	assign s1_load  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_valid_q <= 1'b1;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (push) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1: exact pixel times step products.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			prod_x_s1 <= 39'(px_clamp) * 39'(cfg.step_re);
			prod_y_s1 <= 39'(py_clamp) * 39'(cfg.step_im);
		end
	end

	// Stage 2: offset by the radius and saturate to Q6.26.
	always_ff @(posedge clk) begin
		if (s2_load) begin
			start_s2.zr <= sat32($signed({2'd0, prod_x_s1}) - $signed({12'd0, cfg.radius}));
			start_s2.zi <= sat32($signed({2'd0, prod_y_s1}) - $signed({12'd0, cfg.radius}));
		end
	end

	assign push_valid = s2_valid_q;
	assign push_data  = start_s2;

endmodule

// ===== rtl/jet_queue.sv =====
// Short queue of start points between the front and back parts.
// Two register entries with read and write pointers. Uses jet_pkg and the macro header.
`include "julia_escape_time_top_macros.svh"

module jet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  jet_pkg::point_t push_data,
	output logic            pop_valid,
	input  logic            pop,
	output jet_pkg::point_t pop_data
);
	import jet_pkg::*;

	point_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = ent_q[rd_ptr_q];

	// Pointer and fill-count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	`JET_ASSERT_SAME(a_q_count_bound, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`JET_ASSERT_NEXT(a_q_pop_drains, do_pop && !do_push, count_q == QCNT_W'($past(count_q) - 1'b1), "pop lost")

endmodule

// ===== rtl/jet_back.sv =====
// Back part: iterates z = z*z + c on one start point and holds the result register.
// One iteration is three phases over a shared set of multipliers. Uses jet_pkg and macros.
`include "julia_escape_time_top_macros.svh"

module jet_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jet_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  jet_pkg::point_t q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [15:0]     escape_count
);
	import jet_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]         state_q;
	logic signed [31:0] zr_q, zi_q, im_q;
	logic signed [63:0] rr_q, ii_q, ri_q, diff_q;
	logic [63:0]        sum_q;
	logic [57:0]        lim_q;
	logic [15:0]        iter_q, res_q;
	logic               out_valid_q;
	logic [15:0]        escape_count_q;
	logic               escaped, out_load;

	assign escaped  = sum_q >= {6'd0, lim_q};
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	// Squared radius, refreshed every cycle from the register.
	always_ff @(posedge clk) begin
		lim_q <= 58'(cfg.radius) * 58'(cfg.radius);
	end

	// Iteration sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (iter_q == cfg.iter_limit) ? ST_DONE : ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= escaped ? ST_DONE : ST_MUL;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: products, sums, then escape test and update.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				zr_q   <= q_data.zr;
				zi_q   <= q_data.zi;
				iter_q <= '0;
			end
			ST_MUL: begin
				rr_q <= zr_q * zr_q;
				ii_q <= zi_q * zi_q;
				ri_q <= zr_q * zi_q;
				res_q <= '0;
			end
			ST_ADD: begin
				sum_q  <= $unsigned(rr_q) + $unsigned(ii_q);
				diff_q <= rr_q - ii_q;
				im_q   <= sat32(41'($signed(ri_q[63:25])) + 41'($signed(cfg.c_im)));
			end
			ST_CHK: begin
				if (escaped) begin
					res_q <= iter_q;
				end else begin
					zr_q   <= sat32(41'($signed(diff_q[63:26])) + 41'($signed(cfg.c_re)));
					zi_q   <= im_q;
					iter_q <= iter_q + 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: frees the back part while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			escape_count_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = escape_count_q;

	`JET_ASSERT_SAME(a_iter_bound, state_q != ST_IDLE, iter_q <= cfg.iter_limit, "count past limit")
	`JET_ASSERT_SAME(a_res_range, out_load, res_q == 16'd0 || res_q < cfg.iter_limit, "bad result")
	`JET_ASSERT_NEXT(a_chk_exit, state_q == ST_CHK, state_q == ST_MUL || state_q == ST_DONE, "bad exit")

endmodule

// ===== rtl/julia_escape_time_top.sv =====
// Top level of the Julia escape-time block: configuration registers and part wiring.
// Instantiates jet_front, jet_queue and jet_back; uses jet_pkg.
//
// Usage: a pixel request (pix_x, pix_y) is taken when in_valid is high and in_stall low.
// The result escape_count leaves when out_valid is high and out_stall low, one result
// per request, in request order. Registers are written over cfg_valid/cfg_ready with a
// register index in cfg_index and the value in cfg_data; cfg_ready is always high, and
// writes must be made only while no request is in flight; the block itself does not enforce this.
// The front part takes a request per cycle, unless in_stall is high, into a two-stage
// start-point pipeline and a two-entry queue, so up to four requests can be waiting
// while the back part works. The back part runs one pixel at a time; each iteration
// steps through its multiply, add and check states. It takes a new pixel from the queue
// only after its previous result has gone into the output register.
// Reset clears the pipeline, queue and result register and restores the register
// defaults. While out_stall is high the result is held, the back part waits with its
// finished count, and the front part keeps filling the queue until it is full.
module julia_escape_time_top #(
	parameter int MAX_DIM = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  pix_x,
	input  logic [9:0]  pix_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] escape_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import jet_pkg::*;

	cfg_t   cfg_q;
	logic   push_valid, push_ready, q_valid, q_pop;
	point_t push_data, q_data;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius     <= RADIUS_RST;
			cfg_q.c_re       <= C_RE_RST;
			cfg_q.c_im       <= C_IM_RST;
			cfg_q.iter_limit <= ITER_LIMIT_RST;
			cfg_q.step_re    <= STEP_RST;
			cfg_q.step_im    <= STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS:     cfg_q.radius     <= cfg_data[28:0];
				REG_C_RE:       cfg_q.c_re       <= $signed(cfg_data);
				REG_C_IM:       cfg_q.c_im       <= $signed(cfg_data);
				REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data[15:0];
				REG_STEP_RE:    cfg_q.step_re    <= cfg_data[28:0];
				REG_STEP_IM:    cfg_q.step_im    <= cfg_data[28:0];
				default: begin
				end
			endcase
		end
	end

	jet_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	jet_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	jet_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count)
	);

endmodule

// ===== dv/tb_julia_escape_time_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for julia_escape_time_top: escape counts are predicted per pixel
// request and compared in order. Depends only on jet_pkg and the block's RTL.

module tb_julia_escape_time_top;
	import jet_pkg::*;

	localparam int MAX_DIM        = 1024;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int MAX_REPORTS    = 10;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] data;
		logic [9:0]  px;
		logic [9:0]  py;
		logic        typed;
		logic [15:0] count;
	} dir_row_t;

	typedef enum int {
		PH_DEFAULT, PH_ZOOM, PH_SATURATE, PH_NO_RADIUS, PH_NO_ITER, PH_QUICK_ESCAPE, PH_MIXED
	} phase_kind_t;

	// Local copy of the register file as seen by the predictor.
	typedef struct {
		logic [28:0]        radius;
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
		logic [15:0]        iter_limit;
		logic [28:0]        step_re;
		logic [28:0]        step_im;
	} view_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [9:0]  pix_x = '0;
	logic [9:0]  pix_y = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] escape_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	view_cfg_t   cur;
	logic [15:0] pending_counts [$];
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int unsigned hold_off_len = 0;
	int unsigned quiet_cycles = 0;
	int unsigned n_pixels = 0;
	int unsigned n_results = 0;
	int unsigned n_writes = 0;
	int unsigned n_holdoffs = 0;
	int unsigned n_fail = 0;

	julia_escape_time_top #(.MAX_DIM(MAX_DIM)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pix_x(pix_x),
		.pix_y(pix_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.escape_count(escape_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Clamp to the signed 32-bit range of a Q6.26 value.
	function automatic longint clamp_q(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Escape count of one pixel under the current register values.
	function automatic logic [15:0] escape_count_of(input logic [9:0] px, input logic [9:0] py);
		longint          zr, zi, rr, ii, ri;
		longint unsigned mag, bound;
		int              cx, cy;
		int unsigned     n;
		cx = int'(px);
		cy = int'(py);
		if (cx > MAX_DIM - 1) begin
			cx = MAX_DIM - 1;
		end
		if (cy > MAX_DIM - 1) begin
			cy = MAX_DIM - 1;
		end
		zr = clamp_q(longint'(cx) * longint'(cur.step_re) - longint'(cur.radius));
		zi = clamp_q(longint'(cy) * longint'(cur.step_im) - longint'(cur.radius));
		bound = longint'(cur.radius) * longint'(cur.radius);
		n = 0;
		while (n < cur.iter_limit) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			// The sum can reach 2^63, so it is compared as an unsigned quantity.
			mag = rr + ii;
			if (mag >= bound) begin
				break;
			end
			zr = clamp_q(((rr - ii) >>> 26) + longint'(cur.c_re));
			zi = clamp_q((ri >>> 25) + longint'(cur.c_im));
			n++;
		end
		return (n == cur.iter_limit) ? 16'd0 : n[15:0];
	endfunction

	// Apply a register write to the predictor's copy, keeping only the register's width.
	function automatic void store_reg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			REG_RADIUS:     cur.radius     = data[28:0];
			REG_C_RE:       cur.c_re       = $signed(data);
			REG_C_IM:       cur.c_im       = $signed(data);
			REG_ITER_LIMIT: cur.iter_limit = data[15:0];
			REG_STEP_RE:    cur.step_re    = data[28:0];
			REG_STEP_IM:    cur.step_im    = data[28:0];
			default: ;
		endcase
	endfunction

	function automatic void note_failure(input string what, input logic [15:0] want,
			input logic [15:0] got);
		n_fail++;
		if (n_fail <= MAX_REPORTS) begin
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endfunction

	function automatic dir_row_t px_row(input logic [9:0] x, input logic [9:0] y);
		return '{kind: ROW_PIXEL, px: x, py: y, typed: 1'b0, default: '0};
	endfunction

	function automatic dir_row_t px_known(input logic [9:0] x, input logic [9:0] y,
			input logic [15:0] c);
		return '{kind: ROW_PIXEL, px: x, py: y, typed: 1'b1, count: c, default: '0};
	endfunction

	function automatic dir_row_t reg_row(input logic [2:0] i, input logic [31:0] d);
		return '{kind: ROW_WRITE, idx: i, data: d, default: '0};
	endfunction

	// Directed rows, starting from the reset register values. Counts are typed in only
	// where the start point is plainly outside the radius or the result is forced to zero.
	dir_row_t dir_rows [39] = '{
		// Corners of the default view all start outside the radius.
		px_known(10'd0, 10'd0, 16'd0),
		px_known(10'd1023, 10'd1023, 16'd0),
		px_known(10'd1023, 10'd0, 16'd0),
		px_known(10'd0, 10'd1023, 16'd0),
		px_row(10'd500, 10'd500),
		px_row(10'd650, 10'd520),
		px_row(10'd380, 10'd600),
		// No iterations at all.
		reg_row(REG_ITER_LIMIT, 32'd0),
		px_known(10'd500, 10'd500, 16'd0),
		px_known(10'd0, 10'd0, 16'd0),
		reg_row(REG_ITER_LIMIT, 32'd1),
		px_row(10'd500, 10'd500),
		px_row(10'd0, 10'd0),
		// Zero radius: every point escapes at once, with count zero.
		reg_row(REG_ITER_LIMIT, 32'd24),
		reg_row(REG_RADIUS, 32'd0),
		px_known(10'd500, 10'd500, 16'd0),
		px_known(10'd1023, 10'd1023, 16'd0),
		// A radius and steps of 4.0; the far corner saturates the start point.
		reg_row(REG_RADIUS, 32'd268435456),
		reg_row(REG_STEP_RE, 32'd268435456),
		reg_row(REG_STEP_IM, 32'd268435456),
		px_known(10'd0, 10'd0, 16'd0),
		px_known(10'd1023, 10'd1023, 16'd0),
		px_row(10'd1, 10'd1),
		// Extreme constants drive the iteration into saturation.
		reg_row(REG_C_RE, 32'h8000_0000),
		reg_row(REG_C_IM, 32'h7FFF_FFFF),
		px_row(10'd1, 10'd1),
		px_row(10'd1, 10'd0),
		reg_row(REG_C_RE, 32'h7FFF_FFFF),
		reg_row(REG_C_IM, 32'h8000_0000),
		px_row(10'd1, 10'd1),
		// Zero steps put every pixel on the window corner.
		reg_row(REG_STEP_RE, 32'd0),
		reg_row(REG_STEP_IM, 32'd0),
		px_row(10'd1023, 10'd0),
		px_row(10'd512, 10'd1023),
		// Largest iteration limit, with points that leave after one step.
		reg_row(REG_STEP_RE, 32'd134217728),
		reg_row(REG_STEP_IM, 32'd134217728),
		reg_row(REG_ITER_LIMIT, 32'd65535),
		px_row(10'd2, 10'd2),
		px_row(10'd3, 10'd1)
	};

	// Register write; only issued once every pending result has come back.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		in_valid <= 1'b0;
		while (pending_counts.size() != 0) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		store_reg(idx, data);
		n_writes++;
	endtask

	// Offer one pixel request after a random gap; valid stays high for the next request.
	task automatic send_pixel(input logic [9:0] px, input logic [9:0] py, input logic typed,
			input logic [15:0] count);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 10) : 0;
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pix_x    <= px;
		pix_y    <= py;
		do @(posedge clk); while (in_stall);
		pending_counts.push_back(typed ? count : escape_count_of(px, py));
		n_pixels++;
	endtask

	// One random phase: a fresh register setting of the given kind, then random pixels.
	task automatic run_phase(input phase_kind_t kind, input int n_items);
		logic [31:0] rad, cre, cim, mit, sre, sim, mag;
		logic [9:0]  px, py;
		int unsigned span;
		case (kind)
			PH_DEFAULT: begin
				rad = 32'd134217728;
				cre = -32'sd46976204;
				cim = 32'sd18129543;
				mit = 32'd1000;
				sre = 32'd268435;
				sim = 32'd268435;
			end
			PH_ZOOM: begin
				// A 64 by 64 window over the usual view, with c within one unit.
				rad = 32'd134217728;
				cre = 32'(int'($urandom_range(0, 134217728)) - 67108864);
				cim = 32'(int'($urandom_range(0, 134217728)) - 67108864);
				mit = $urandom_range(16, 100);
				sre = 32'd4194304;
				sim = 32'd4194304;
			end
			PH_SATURATE: begin
				// Unused upper bits of the step writes are random on purpose.
				rad = $urandom_range(268435456, 536870911);
				cre = $urandom;
				cim = $urandom;
				mit = $urandom_range(1, 8);
				sre = $urandom;
				sim = $urandom;
			end
			PH_NO_RADIUS: begin
				rad = 32'd0;
				cre = $urandom;
				cim = $urandom;
				mit = $urandom_range(1, 65535);
				sre = $urandom_range(0, 536870911);
				sim = $urandom_range(0, 536870911);
			end
			PH_NO_ITER: begin
				rad = $urandom_range(0, 536870911);
				cre = $urandom;
				cim = $urandom;
				mit = 32'd0;
				sre = $urandom_range(0, 536870911);
				sim = $urandom_range(0, 536870911);
			end
			PH_QUICK_ESCAPE: begin
				// With |c_re| of at least 8 and a radius of at most 2, every point is
				// gone after one iteration, so the top limit costs no time.
				mag = $urandom_range(536870912, 2147483647);
				rad = $urandom_range(33554432, 134217728);
				cre = $urandom_range(0, 1) ? mag : -mag;
				cim = $urandom;
				mit = 32'd65535;
				sre = $urandom_range(65536, 4194304);
				sim = $urandom_range(65536, 4194304);
			end
			default: begin
				rad = $urandom_range(67108864, 268435456);
				cre = 32'(int'($urandom_range(0, 201326592)) - 100663296);
				cim = 32'(int'($urandom_range(0, 201326592)) - 100663296);
				mit = $urandom_range(1, 64);
				sre = $urandom_range(131072, 16777216);
				sim = $urandom_range(131072, 16777216);
			end
		endcase
		write_reg(REG_RADIUS, rad);
		write_reg(REG_C_RE, cre);
		write_reg(REG_C_IM, cim);
		write_reg(REG_ITER_LIMIT, mit);
		write_reg(REG_STEP_RE, sre);
		write_reg(REG_STEP_IM, sim);

		for (int i = 0; i < n_items; i++) begin
			// Idling comes and goes in stretches of forty requests.
			if (i % 40 == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			// Receiver holds off while the sender keeps the input busy.
			if (kind == PH_MIXED && i == 50) begin
				hold_off_len = HOLD_OFF_LEN;
				tx_idle_on   = 1'b0;
			end
			span = (kind == PH_ZOOM && $urandom_range(0, 99) < 85) ? 63 : 1023;
			px = 10'($urandom_range(0, span));
			py = 10'($urandom_range(0, span));
			send_pixel(px, py, 1'b0, 16'd0);
		end
	endtask

	// Result side: random stall before each result, with an occasional long hold-off.
	initial begin : receiver
		int unsigned wait_n;
		forever begin
			if (hold_off_len != 0) begin
				wait_n       = hold_off_len;
				hold_off_len = 0;
				n_holdoffs++;
			end else begin
				wait_n = rx_idle_on ? $urandom_range(0, 10) : 0;
			end
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Result checking and the watchdog on handshake activity.
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (pending_counts.size() == 0) begin
					note_failure("result with no request pending", 16'd0, escape_count);
				end else begin
					want = pending_counts.pop_front();
					if (escape_count !== want) begin
						note_failure("escape_count mismatch", want, escape_count);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results pending",
					quiet_cycles, pending_counts.size());
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin : stimulus
		cur.radius     = 29'd134217728;
		cur.c_re       = -32'sd46976204;
		cur.c_im       = 32'sd18129543;
		cur.iter_limit = 16'd1000;
		cur.step_re    = 29'd268435;
		cur.step_im    = 29'd268435;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_WRITE) begin
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				send_pixel(dir_rows[r].px, dir_rows[r].py, dir_rows[r].typed,
					dir_rows[r].count);
			end
		end

		run_phase(PH_DEFAULT, 50);
		run_phase(PH_ZOOM, 180);
		run_phase(PH_SATURATE, 80);
		run_phase(PH_NO_RADIUS, 30);
		run_phase(PH_NO_ITER, 30);
		run_phase(PH_QUICK_ESCAPE, 40);
		run_phase(PH_MIXED, 200);

		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_counts.size() != 0) begin
			@(posedge clk);
		end
		// Keep running for DRAIN_CYCLES so that a stray extra result would still be caught.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d pixel requests over %0d directed rows and 7 register settings,",
			n_pixels, $size(dir_rows));
		$display("summary: %0d register writes, %0d results, %0d long hold-offs, %0d failures",
			n_writes, n_results, n_holdoffs, n_fail);
		if (n_fail == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
